/* src/drive_enable_sequencer_core_assert.svh */
// Assertion macros shared by the drive enable sequencer RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef DRIVE_ENABLE_SEQUENCER_CORE_ASSERT_SVH
`define DRIVE_ENABLE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drive enable sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drive enable sequencer check failed");

`endif

/* src/des_pkg.sv */
// Types, codes and constants of the drive enable sequencer.
// No dependencies; used by des_front, des_queue, des_back and the top level.
package des_pkg;

  typedef enum logic [2:0] {
    OP_STATUS  = 3'd0,
    OP_ENABLE  = 3'd1,
    OP_DISABLE = 3'd2,
    OP_TARGET  = 3'd3,
    OP_TIMEOUT = 3'd4,
    OP_EMCY    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_CONTROL = 2'd0,
    KIND_READ    = 2'd1,
    KIND_BATTERY = 2'd2,
    KIND_REPLY   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RS_OK          = 2'd0,
    RS_NOT_OPER    = 2'd1,
    RS_FAULTED     = 2'd2
  } rstat_e;

  // Configuration register indexes.
  localparam logic REG_POSITION_MODE = 1'b0;
  localparam logic REG_NODE_ID       = 1'b1;
  localparam logic [6:0] NODE_ID_RESET = 7'd1;

  // Control words.
  localparam logic [7:0] CW_FAULT_RESET = 8'h80;
  localparam logic [7:0] CW_SHUTDOWN    = 8'h06;
  localparam logic [7:0] CW_SWITCH_ON   = 8'h07;
  localparam logic [7:0] CW_ENABLE_OP   = 8'h0F;
  localparam logic [7:0] CW_SETPOINT    = 8'h3F;
  localparam logic [7:0] CW_NONE        = 8'h00;

  // Low nibble of the status word.
  localparam logic [3:0] SW_STATE_IDLE       = 4'h0;
  localparam logic [3:0] SW_STATE_READY      = 4'h1;
  localparam logic [3:0] SW_STATE_SWITCHED   = 4'h3;
  localparam logic [3:0] SW_STATE_OPERATION  = 4'h7;
  localparam int         SW_FAULT_BIT        = 3;

  localparam logic [10:0] ID_CONTROL_BASE = 11'h200;
  localparam logic [10:0] ID_SDO_BASE     = 11'h600;
  localparam logic [10:0] ID_NONE         = 11'h000;

  localparam logic [15:0] CODE_TIMEOUT = 16'hFFFF;
  localparam logic [31:0] BATTERY_RESET_VALUE = 32'd1;

  localparam int NUM_KNOWN_CODES = 25;
  localparam logic [15:0] KNOWN_CODES [NUM_KNOWN_CODES] = '{
    16'h2340, 16'h3120, 16'h3310, 16'h3333, 16'h4310, 16'h5280, 16'h5281,
    16'h5400, 16'h5441, 16'h6180, 16'h6181, 16'h6320, 16'h7121, 16'h7300,
    16'h7380, 16'h7381, 16'h8130, 16'h8311, 16'h8380, 16'h8381, 16'h8480,
    16'h8481, 16'h8611, 16'h8680, 16'hFF10
  };

  // One accepted item as handed from the front end to the frame builder.
  typedef struct packed {
    logic        reply;
    logic        do_read;
    logic        faulted;
    logic [7:0]  ctrl;
    logic [31:0] target;
    logic [1:0]  rstat;
    logic [15:0] fcode;
    logic        oper;
  } cmd_t;

  function automatic logic is_known_code(input logic [15:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_KNOWN_CODES; i++) begin
      if (KNOWN_CODES[i] == code) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

/* src/des_front.sv */
// Front end: accepts items, updates the enable sequence state, emits commands.
// Depends on des_pkg.
module des_front #(
  parameter int ENABLE_DELAY      = 150,
  parameter int ERROR_READ_PERIOD = 50,
  parameter int FAULT_COUNT_LIMIT = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [2:0]         operation_i,
  input  logic [15:0]        status_word_i,
  input  logic [31:0]        new_target_i,
  input  logic [15:0]        emergency_code_i,
  input  logic               position_mode_i,
  output des_pkg::cmd_t      cmd_o
);

  localparam int SdW = $clog2(ENABLE_DELAY + 1);
  localparam int PhW = $clog2(ERROR_READ_PERIOD);
  localparam int FfW = $clog2(FAULT_COUNT_LIMIT + 2);

  logic           en_q, en_d;
  logic           rp_q, rp_d;
  logic           fault_q, fault_d;
  logic [15:0]    code_q, code_d;
  logic [PhW-1:0] ph_q, ph_d;
  logic [FfW-1:0] ff_q, ff_d;
  logic [SdW-1:0] sd_q, sd_d;
  logic           oper_q, oper_d;
  logic           tog_q, tog_d;
  logic [7:0]     hc_q, hc_d;
  logic [31:0]    ht_q, ht_d;

  logic           faulted;
  logic [3:0]     st;
  logic [PhW:0]   ph_inc;
  logic           do_read;
  logic [1:0]     rstat;

  always_comb begin
    en_d    = en_q;
    rp_d    = rp_q;
    fault_d = fault_q;
    code_d  = code_q;
    ph_d    = ph_q;
    ff_d    = ff_q;
    sd_d    = sd_q;
    oper_d  = oper_q;
    tog_d   = tog_q;
    hc_d    = hc_q;
    ht_d    = ht_q;
    faulted = status_word_i[des_pkg::SW_FAULT_BIT];
    st      = status_word_i[3:0];
    ph_inc  = {1'b0, ph_q} + (PhW + 1)'(1);
    do_read = 1'b0;
    rstat   = des_pkg::RS_OK;

    case (des_pkg::op_e'(operation_i))
      des_pkg::OP_STATUS: begin
        if (faulted && rp_q) begin
          hc_d = des_pkg::CW_FAULT_RESET;
          ht_d = '0;
        end else begin
          rp_d = 1'b0;
        end
        if (en_q && !rp_d) begin
          if (sd_q != '0) sd_d = sd_q - SdW'(1);
          case (st)
            des_pkg::SW_STATE_IDLE:      hc_d = des_pkg::CW_SHUTDOWN;
            des_pkg::SW_STATE_READY:     hc_d = des_pkg::CW_SWITCH_ON;
            des_pkg::SW_STATE_SWITCHED:  hc_d = des_pkg::CW_ENABLE_OP;
            des_pkg::SW_STATE_OPERATION: ;
            default:                     en_d = 1'b0;
          endcase
        end
        oper_d = (st == des_pkg::SW_STATE_OPERATION);
        if (position_mode_i && oper_d) begin
          hc_d  = tog_q ? des_pkg::CW_ENABLE_OP : des_pkg::CW_SETPOINT;
          tog_d = !tog_q;
        end
        if (!en_d && !rp_d) hc_d = des_pkg::CW_NONE;
        if (faulted) begin
          do_read = (ph_q == PhW'(1));
          ph_d    = (ph_inc >= (PhW + 1)'(ERROR_READ_PERIOD)) ? '0 : ph_inc[PhW-1:0];
          if (ff_q <= FfW'(FAULT_COUNT_LIMIT)) ff_d = ff_q + FfW'(1);
          if (ff_d > FfW'(FAULT_COUNT_LIMIT)) fault_d = 1'b1;
        end else begin
          ph_d    = '0;
          ff_d    = '0;
          fault_d = 1'b0;
        end
      end
      des_pkg::OP_ENABLE: begin
        sd_d = SdW'(ENABLE_DELAY);
        rp_d = 1'b1;
        en_d = 1'b1;
      end
      des_pkg::OP_DISABLE: en_d = 1'b0;
      des_pkg::OP_TARGET: begin
        ht_d = new_target_i;
        if (fault_q) rstat = des_pkg::RS_FAULTED;
        else if (!oper_q && sd_q == '0) rstat = des_pkg::RS_NOT_OPER;
      end
      des_pkg::OP_TIMEOUT: begin
        fault_d = 1'b1;
        code_d  = des_pkg::CODE_TIMEOUT;
      end
      des_pkg::OP_EMCY: begin
        if (des_pkg::is_known_code(emergency_code_i)) code_d = emergency_code_i;
      end
      default: ;
    endcase

    cmd_o.reply   = (operation_i != des_pkg::OP_STATUS);
    cmd_o.do_read = do_read;
    cmd_o.faulted = faulted && (operation_i == des_pkg::OP_STATUS);
    cmd_o.ctrl    = hc_d;
    cmd_o.target  = ht_d;
    cmd_o.rstat   = rstat;
    cmd_o.fcode   = fault_d ? code_d : 16'h0000;
    cmd_o.oper    = oper_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      rp_q    <= 1'b0;
      fault_q <= 1'b0;
      code_q  <= '0;
      ph_q    <= '0;
      ff_q    <= '0;
      sd_q    <= '0;
      oper_q  <= 1'b0;
      tog_q   <= 1'b0;
      hc_q    <= '0;
      ht_q    <= '0;
    end else if (accept_i) begin
      en_q    <= en_d;
      rp_q    <= rp_d;
      fault_q <= fault_d;
      code_q  <= code_d;
      ph_q    <= ph_d;
      ff_q    <= ff_d;
      sd_q    <= sd_d;
      oper_q  <= oper_d;
      tog_q   <= tog_d;
      hc_q    <= hc_d;
      ht_q    <= ht_d;
    end
  end

endmodule

/* src/des_queue.sv */
// Two-entry command queue between the front end and the frame builder.
// Depends on des_pkg for the command type.
module des_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  des_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output des_pkg::cmd_t rdata_o
);

  des_pkg::cmd_t mem_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* src/des_back.sv */
// Frame builder: expands each command into its frames and holds the output register.
// Depends on des_pkg and the assertion macro header.
`include "drive_enable_sequencer_core_assert.svh"

module des_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  des_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic [6:0]         node_id_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [1:0]         frame_kind_o,
  output logic [10:0]        frame_id_o,
  output logic [7:0]         control_word_o,
  output logic signed [31:0] target_value_o,
  output logic [1:0]         return_status_o,
  output logic [15:0]        fault_code_o,
  output logic               is_operational_o,
  output logic               last_o
);

  logic          out_valid_q, out_valid_d;
  logic          sent_read_q, sent_read_d;
  logic          sent_batt_q, sent_batt_d;
  logic          adv;
  des_pkg::kind_e kind;
  logic          frame_last;
  logic [10:0]   id_d;
  logic [7:0]    ctrl_d;
  logic [31:0]   tgt_d;
  logic [1:0]    rs_d;

  logic [1:0]    kind_q;
  logic [10:0]   id_q;
  logic [7:0]    ctrl_q;
  logic [31:0]   tgt_q;
  logic [1:0]    rs_q;
  logic [15:0]   fcode_q;
  logic          oper_q;
  logic          last_q;

  always_comb begin
    adv = cmd_valid_i && (!out_valid_q || pop_i);
    if (cmd_i.reply) kind = des_pkg::KIND_REPLY;
    else if (cmd_i.do_read && !sent_read_q) kind = des_pkg::KIND_READ;
    else if (cmd_i.faulted && !sent_batt_q) kind = des_pkg::KIND_BATTERY;
    else kind = des_pkg::KIND_CONTROL;
    frame_last = (kind == des_pkg::KIND_REPLY) || (kind == des_pkg::KIND_CONTROL);

    id_d   = des_pkg::ID_NONE;
    ctrl_d = des_pkg::CW_NONE;
    tgt_d  = '0;
    rs_d   = des_pkg::RS_OK;
    case (kind)
      des_pkg::KIND_CONTROL: begin
        id_d   = des_pkg::ID_CONTROL_BASE + 11'(node_id_i);
        ctrl_d = cmd_i.ctrl;
        tgt_d  = cmd_i.target;
      end
      des_pkg::KIND_READ:    id_d = des_pkg::ID_SDO_BASE + 11'(node_id_i);
      des_pkg::KIND_BATTERY: begin
        id_d  = des_pkg::ID_SDO_BASE + 11'(node_id_i);
        tgt_d = des_pkg::BATTERY_RESET_VALUE;
      end
      des_pkg::KIND_REPLY:   rs_d = cmd_i.rstat;
      default: ;
    endcase

    sent_read_d = sent_read_q;
    sent_batt_d = sent_batt_q;
    if (adv) begin
      if (frame_last) begin
        sent_read_d = 1'b0;
        sent_batt_d = 1'b0;
      end else if (kind == des_pkg::KIND_READ) begin
        sent_read_d = 1'b1;
      end else begin
        sent_batt_d = 1'b1;
      end
    end

    if (adv) out_valid_d = 1'b1;
    else if (pop_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign cmd_pop_o = adv && frame_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_read_q <= 1'b0;
      sent_batt_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sent_read_q <= sent_read_d;
      sent_batt_q <= sent_batt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q  <= kind;
      id_q    <= id_d;
      ctrl_q  <= ctrl_d;
      tgt_q   <= tgt_d;
      rs_q    <= rs_d;
      fcode_q <= cmd_i.fcode;
      oper_q  <= cmd_i.oper;
      last_q  <= frame_last;
    end
  end

  assign empty_o          = !out_valid_q;
  assign frame_kind_o     = kind_q;
  assign frame_id_o       = id_q;
  assign control_word_o   = ctrl_q;
  assign target_value_o   = tgt_q;
  assign return_status_o  = rs_q;
  assign fault_code_o     = fcode_q;
  assign is_operational_o = oper_q;
  assign last_o           = last_q;

  // A partly sent command stays at the head of the queue until its last frame.
  `DES_ASSERT_NOW(a_partial_held, clk_i, rst_ni, sent_read_q || sent_batt_q, cmd_valid_i)
  // Frames of one item leave back to back: a non-last frame taken is replaced at once.
  `DES_ASSERT_NEXT(a_no_gap, clk_i, rst_ni, out_valid_q && !last_q && pop_i, out_valid_q)
  // An error-code read request is always followed by the battery-error write.
  `DES_ASSERT_NEXT(a_read_then_batt, clk_i, rst_ni,
                   out_valid_q && pop_i && (kind_q == des_pkg::KIND_READ),
                   kind_q == des_pkg::KIND_BATTERY)

endmodule

/* src/drive_enable_sequencer_core.sv */
// Accepted items are queued as commands whose frames then fill the output register.
// Throughput: one item accepted per cycle while the two-entry command queue has room;
// the frame builder delivers one result per cycle while results are popped; a
// status item yields one to three frames and every other operation one.
// Reset (rst_ni low, asynchronous) clears all sequence state, empties the queue and
// output register, and returns position_mode to 0 and node_id to 1.
module drive_enable_sequencer_core #(
  parameter int ENABLE_DELAY      = 150,
  parameter int ERROR_READ_PERIOD = 50,
  parameter int FAULT_COUNT_LIMIT = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item side.
  input  logic               push,
  output logic               full,
  input  logic [2:0]         operation_i,
  input  logic [15:0]        status_word_i,
  input  logic signed [31:0] new_target_i,
  input  logic [15:0]        emergency_code_i,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  // Result side.
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         frame_kind_o,
  output logic [10:0]        frame_id_o,
  output logic [7:0]         control_word_o,
  output logic signed [31:0] target_value_o,
  output logic [1:0]         return_status_o,
  output logic [15:0]        fault_code_o,
  output logic               is_operational_o,
  output logic               last_o
);

  // Configuration registers. Writes are always taken; the write data is cut to
  // the width of the addressed register.
  logic       position_mode_q, position_mode_d;
  logic [6:0] node_id_q, node_id_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    position_mode_d = position_mode_q;
    node_id_d       = node_id_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        des_pkg::REG_POSITION_MODE: position_mode_d = cfg_data_i[0];
        des_pkg::REG_NODE_ID:       node_id_d       = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_mode_q <= 1'b0;
      node_id_q       <= des_pkg::NODE_ID_RESET;
    end else begin
      position_mode_q <= position_mode_d;
      node_id_q       <= node_id_d;
    end
  end

  // The front end commits the full state update of an item in the cycle it is
  // accepted and hands one command describing all of its frames to the queue.
  logic          accept;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  des_pkg::cmd_t front_cmd;
  des_pkg::cmd_t head_cmd;

  assign full   = q_full;
  assign accept = push && !q_full;

  des_front #(
    .ENABLE_DELAY      (ENABLE_DELAY),
    .ERROR_READ_PERIOD (ERROR_READ_PERIOD),
    .FAULT_COUNT_LIMIT (FAULT_COUNT_LIMIT)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .operation_i      (operation_i),
    .status_word_i    (status_word_i),
    .new_target_i     (new_target_i),
    .emergency_code_i (emergency_code_i),
    .position_mode_i  (position_mode_q),
    .cmd_o            (front_cmd)
  );

  des_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (head_cmd)
  );

  // The back end walks the head command frame by frame into the output register,
  // refilled in the same cycle a result transfer completes if a command waits.
  des_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (head_cmd),
    .cmd_pop_o        (q_pop),
    .node_id_i        (node_id_q),
    .pop_i            (pop),
    .empty_o          (empty),
    .frame_kind_o     (frame_kind_o),
    .frame_id_o       (frame_id_o),
    .control_word_o   (control_word_o),
    .target_value_o   (target_value_o),
    .return_status_o  (return_status_o),
    .fault_code_o     (fault_code_o),
    .is_operational_o (is_operational_o),
    .last_o           (last_o)
  );

endmodule

/* tb/drive_enable_sequencer_core_test.sv */
// Self-checking testbench for drive_enable_sequencer_core: it queues drive items, predicts
// every frame the sequencer emits, and compares each accepted frame field by field.
// Depends on des_pkg and the drive_enable_sequencer_core RTL.
module drive_enable_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Block parameters, passed to the instance so the prediction uses the same values.
  localparam int SETTLE_FRAMES    = 150;
  localparam int READ_EVERY       = 50;
  localparam int FAULT_FRAMES_MAX = 5;

  // A run is declared hung once this many cycles pass with no transfer on any channel.
  localparam int WATCHDOG_CYCLES = 2000;

  // Control words the master places in its control frame.
  localparam logic [7:0] CTRL_OFF          = 8'h00;
  localparam logic [7:0] CTRL_SHUTDOWN     = 8'h06;
  localparam logic [7:0] CTRL_SWITCH_ON    = 8'h07;
  localparam logic [7:0] CTRL_ENABLE_OP    = 8'h0F;
  localparam logic [7:0] CTRL_NEW_SETPOINT = 8'h3F;
  localparam logic [7:0] CTRL_FAULT_RESET  = 8'h80;

  // Low nibble of the drive status word. Bit 3 of the word is the fault bit.
  localparam logic [3:0] NIB_NOT_READY   = 4'h0;
  localparam logic [3:0] NIB_READY       = 4'h1;
  localparam logic [3:0] NIB_SWITCHED_ON = 4'h3;
  localparam logic [3:0] NIB_OP_ENABLED  = 4'h7;
  localparam int         FAULT_BIT       = 3;

  localparam logic [10:0] CTRL_FRAME_BASE = 11'h200;
  localparam logic [10:0] SDO_FRAME_BASE  = 11'h600;
  localparam logic [15:0] TIMEOUT_CODE    = 16'hFFFF;
  localparam logic [31:0] BATTERY_CLEAR   = 32'd1;
  localparam logic [6:0]  NODE_AFTER_RESET = 7'd1;

  // Operation codes the block does not define; they must still be answered.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // Emergency codes that the sequencer stores; anything else leaves the stored code alone.
  localparam logic [15:0] EMCY_LIST [25] = '{
    16'h2340, 16'h3120, 16'h3310, 16'h3333, 16'h4310, 16'h5280, 16'h5281, 16'h5400,
    16'h5441, 16'h6180, 16'h6181, 16'h6320, 16'h7121, 16'h7300, 16'h7380, 16'h7381,
    16'h8130, 16'h8311, 16'h8380, 16'h8381, 16'h8480, 16'h8481, 16'h8611, 16'h8680,
    16'hFF10
  };

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] sw;
    logic [31:0] tgt;
    logic [15:0] code;
  } item_t;

  typedef struct packed {
    des_pkg::kind_e  kind;
    logic [10:0]     id;
    logic [7:0]      ctrl;
    logic [31:0]     value;
    des_pkg::rstat_e rs;
    logic [15:0]     fault;
    logic            oper;
    logic            last;
  } frame_t;

  // Every input starts at a known value; reset is held low from time zero.
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               push             = 1'b0;
  logic               full;
  logic [2:0]         operation_i      = '0;
  logic [15:0]        status_word_i    = '0;
  logic signed [31:0] new_target_i     = '0;
  logic [15:0]        emergency_code_i = '0;
  logic               cfg_valid_i      = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i      = 1'b0;
  logic [6:0]         cfg_data_i       = '0;
  logic               empty;
  logic               pop              = 1'b0;
  logic [1:0]         frame_kind_o;
  logic [10:0]        frame_id_o;
  logic [7:0]         control_word_o;
  logic signed [31:0] target_value_o;
  logic [1:0]         return_status_o;
  logic [15:0]        fault_code_o;
  logic               is_operational_o;
  logic               last_o;

  drive_enable_sequencer_core #(
    .ENABLE_DELAY     (SETTLE_FRAMES),
    .ERROR_READ_PERIOD(READ_EVERY),
    .FAULT_COUNT_LIMIT(FAULT_FRAMES_MAX)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .status_word_i   (status_word_i),
    .new_target_i    (new_target_i),
    .emergency_code_i(emergency_code_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .empty           (empty),
    .pop             (pop),
    .frame_kind_o    (frame_kind_o),
    .frame_id_o      (frame_id_o),
    .control_word_o  (control_word_o),
    .target_value_o  (target_value_o),
    .return_status_o (return_status_o),
    .fault_code_o    (fault_code_o),
    .is_operational_o(is_operational_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and expectation stores.
  item_t  items_waiting [$];
  frame_t frames_due [$];
  int     items_total    = 0;
  int     items_accepted = 0;
  int     error_count    = 0;
  int     stall_cycles   = 0;
  int     stall_odds     = 3;   // 0 turns idling off on both sides
  int     send_gap       = 0;
  int     take_gap       = 0;
  logic   item_taken     = 1'b0;

  // Configuration as the sequencer should currently hold it.
  logic       cfg_pos_mode = 1'b0;
  logic [6:0] cfg_node     = NODE_AFTER_RESET;

  // Predicted sequence state, all cleared by the single reset at the start of the run.
  logic        drive_enabled     = 1'b0;
  logic        fault_reset_armed = 1'b0;
  logic        fault_latched     = 1'b0;
  logic [15:0] error_code        = '0;
  int          read_phase        = 0;
  int          faulted_run       = 0;
  int          settle_count      = 0;
  logic        drive_oper        = 1'b0;
  logic        toggle_bit        = 1'b0;
  logic [7:0]  ctrl_held         = CTRL_OFF;
  logic [31:0] target_held       = '0;

  task automatic note_error(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Applies one accepted item to the predicted state and queues the frames it must produce.
  function automatic void advance_drive(input logic [2:0] op, input logic [15:0] sw,
                                        input logic [31:0] tgt, input logic [15:0] code);
    logic            faulted;
    logic [3:0]      nib;
    logic [10:0]     sdo_id;
    logic            do_read;
    logic [15:0]     shown;
    des_pkg::rstat_e rs;
    faulted = sw[FAULT_BIT];
    nib     = sw[3:0];
    sdo_id  = SDO_FRAME_BASE + {4'b0, cfg_node};
    do_read = 1'b0;
    rs      = des_pkg::RS_OK;
    if (op == des_pkg::OP_STATUS) begin
      // A faulted drive with a reset pending gets the fault-reset word and a zero target.
      if (faulted && fault_reset_armed) begin
        ctrl_held   = CTRL_FAULT_RESET;
        target_held = '0;
      end else begin
        fault_reset_armed = 1'b0;
      end
      // Walk the drive through shutdown, switch on and enable operation.
      if (drive_enabled && !fault_reset_armed) begin
        if (settle_count > 0) settle_count--;
        case (nib)
          NIB_NOT_READY:   ctrl_held = CTRL_SHUTDOWN;
          NIB_READY:       ctrl_held = CTRL_SWITCH_ON;
          NIB_SWITCHED_ON: ctrl_held = CTRL_ENABLE_OP;
          NIB_OP_ENABLED: begin
          end
          default:         drive_enabled = 1'b0;
        endcase
      end
      drive_oper = (nib == NIB_OP_ENABLED);
      // Position mode flips the new-setpoint bit on every operational frame.
      if (cfg_pos_mode && drive_oper) begin
        ctrl_held  = toggle_bit ? CTRL_ENABLE_OP : CTRL_NEW_SETPOINT;
        toggle_bit = !toggle_bit;
      end
      if (!drive_enabled && !fault_reset_armed) ctrl_held = CTRL_OFF;
      if (faulted) begin
        do_read = (read_phase == 1);
        if (read_phase + 1 >= READ_EVERY) read_phase = 0;
        else read_phase++;
        if (faulted_run <= FAULT_FRAMES_MAX) faulted_run++;
        if (faulted_run > FAULT_FRAMES_MAX) fault_latched = 1'b1;
      end else begin
        read_phase    = 0;
        faulted_run   = 0;
        fault_latched = 1'b0;
      end
      // Every frame of the item reports the fault state as it stands after the item.
      shown = fault_latched ? error_code : 16'h0000;
      if (do_read) begin
        frames_due.push_back('{des_pkg::KIND_READ, sdo_id, CTRL_OFF, 32'd0, des_pkg::RS_OK,
                               shown, drive_oper, 1'b0});
      end
      if (faulted) begin
        frames_due.push_back('{des_pkg::KIND_BATTERY, sdo_id, CTRL_OFF, BATTERY_CLEAR,
                               des_pkg::RS_OK, shown, drive_oper, 1'b0});
      end
      frames_due.push_back('{des_pkg::KIND_CONTROL, CTRL_FRAME_BASE + {4'b0, cfg_node},
                             ctrl_held, target_held, des_pkg::RS_OK, shown, drive_oper,
                             1'b1});
    end else begin
      case (op)
        des_pkg::OP_ENABLE: begin
          settle_count      = SETTLE_FRAMES;
          fault_reset_armed = 1'b1;
          drive_enabled     = 1'b1;
        end
        des_pkg::OP_DISABLE: drive_enabled = 1'b0;
        des_pkg::OP_TARGET: begin
          target_held = tgt;
          if (fault_latched) rs = des_pkg::RS_FAULTED;
          else if (!drive_oper && settle_count == 0) rs = des_pkg::RS_NOT_OPER;
        end
        des_pkg::OP_TIMEOUT: begin
          fault_latched = 1'b1;
          error_code    = TIMEOUT_CODE;
        end
        des_pkg::OP_EMCY: begin
          foreach (EMCY_LIST[i]) if (EMCY_LIST[i] == code) error_code = code;
        end
        default: begin
        end
      endcase
      shown = fault_latched ? error_code : 16'h0000;
      frames_due.push_back('{des_pkg::KIND_REPLY, 11'h000, CTRL_OFF, 32'd0, rs, shown,
                             drive_oper, 1'b1});
    end
  endfunction

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) note_error($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // Checks the frame on the result ports against the oldest expectation.
  task automatic check_frame();
    frame_t want;
    if (frames_due.size() == 0) begin
      note_error($sformatf("frame of kind %0d with no prediction waiting", frame_kind_o));
      return;
    end
    want = frames_due.pop_front();
    compare_field("frame_kind", {30'b0, frame_kind_o}, {30'b0, want.kind});
    compare_field("frame_id", {21'b0, frame_id_o}, {21'b0, want.id});
    compare_field("control_word", {24'b0, control_word_o}, {24'b0, want.ctrl});
    compare_field("target_value", target_value_o, want.value);
    compare_field("return_status", {30'b0, return_status_o}, {30'b0, want.rs});
    compare_field("fault_code", {16'b0, fault_code_o}, {16'b0, want.fault});
    compare_field("is_operational", {31'b0, is_operational_o}, {31'b0, want.oper});
    compare_field("last", {31'b0, last_o}, {31'b0, want.last});
  endtask

  // Item driver. Inputs change on the falling edge; an item stays on the ports until a
  // rising edge sees push high with full low. While idle the payload carries noise.
  always @(negedge clk_i) begin : feed_items
    item_t nxt;
    logic  sending;
    if (push && !item_taken) begin
      // Hold the current item until the transfer happens.
    end else begin
      sending = 1'b0;
      nxt     = '0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (rst_ni && items_waiting.size() != 0) begin
        if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
          send_gap = $urandom_range(0, 4);
        end else begin
          nxt     = items_waiting.pop_front();
          sending = 1'b1;
        end
      end
      if (!sending) begin
        nxt.op   = 3'($urandom);
        nxt.sw   = 16'($urandom);
        nxt.tgt  = $urandom;
        nxt.code = 16'($urandom);
      end
      push             <= sending;
      operation_i      <= nxt.op;
      status_word_i    <= nxt.sw;
      new_target_i     <= nxt.tgt;
      emergency_code_i <= nxt.code;
    end
  end

  // Result receiver: pop is high except during reset and random stall bursts.
  always @(negedge clk_i) begin : drain_frames
    if (take_gap > 0) begin
      take_gap--;
      pop <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      take_gap = $urandom_range(0, 4);
      pop      <= 1'b0;
    end else begin
      pop <= rst_ni;
    end
  end

  // Monitor. All handshakes are sampled on the rising edge; an accepted item is predicted
  // before the result side is checked, so even a same-cycle answer would compare right.
  always @(posedge clk_i) begin : watch_ports
    if (!rst_ni) begin
      item_taken   = 1'b0;
      stall_cycles = 0;
    end else begin
      item_taken = push && !full;
      if (item_taken) begin
        advance_drive(operation_i, status_word_i, new_target_i, emergency_code_i);
        items_accepted++;
      end
      if (pop && !empty) check_frame();
      if (item_taken || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  function automatic void add_item(input logic [2:0] op, input logic [31:0] sw,
                                   input logic [31:0] tgt, input logic [31:0] code);
    items_waiting.push_back('{op, sw[15:0], tgt, code[15:0]});
    items_total++;
  endfunction

  // Status word with the given low nibble and random upper bits.
  function automatic logic [31:0] sw_with(input logic [3:0] nib);
    logic [31:0] r;
    r      = $urandom;
    r[3:0] = nib;
    return r;
  endfunction

  // Random status word with the fault bit set.
  function automatic logic [31:0] faulted_word();
    logic [31:0] r;
    r            = $urandom;
    r[FAULT_BIT] = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] any_emcy();
    if ($urandom_range(0, 1) == 1) return {16'h0, EMCY_LIST[$urandom_range(0, 24)]};
    return $urandom;
  endfunction

  // One well-formed enable handshake: enable, a few faulted frames that see the fault
  // reset, the three steps up to operation enabled, then operational frames with targets.
  function automatic void queue_enable_run();
    add_item(des_pkg::OP_ENABLE, $urandom, $urandom, $urandom);
    repeat ($urandom_range(0, 2)) begin
      add_item(des_pkg::OP_STATUS, faulted_word(), $urandom, $urandom);
    end
    add_item(des_pkg::OP_STATUS, sw_with(NIB_NOT_READY), $urandom, $urandom);
    add_item(des_pkg::OP_STATUS, sw_with(NIB_READY), $urandom, $urandom);
    add_item(des_pkg::OP_STATUS, sw_with(NIB_SWITCHED_ON), $urandom, $urandom);
    repeat ($urandom_range(1, 8)) begin
      add_item(des_pkg::OP_STATUS, sw_with(NIB_OP_ENABLED), $urandom, $urandom);
      if ($urandom_range(0, 2) == 0) add_item(des_pkg::OP_TARGET, $urandom, $urandom, $urandom);
    end
    if ($urandom_range(0, 1) == 1) add_item(des_pkg::OP_DISABLE, $urandom, $urandom, $urandom);
  endfunction

  function automatic void queue_fault_run(input int len);
    repeat (len) add_item(des_pkg::OP_STATUS, faulted_word(), $urandom, $urandom);
  endfunction

  // Random part of a phase: well-formed sequences, fault episodes,
  // timeouts, emergency codes and plain noise over all eight operation codes.
  task automatic queue_random_phase(input int count);
    int stop_at;
    stop_at = items_total + count;
    while (items_total < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_enable_run();
        4, 5: begin
          queue_fault_run($urandom_range(1, 8));
          add_item(des_pkg::OP_EMCY, $urandom, $urandom, any_emcy());
          add_item(des_pkg::OP_TARGET, $urandom, $urandom, $urandom);
        end
        6: begin
          add_item(des_pkg::OP_TIMEOUT, $urandom, $urandom, $urandom);
          add_item(des_pkg::OP_TARGET, $urandom, $urandom, $urandom);
          add_item(des_pkg::OP_STATUS, $urandom, $urandom, $urandom);
        end
        default: begin
          repeat ($urandom_range(1, 3)) begin
            add_item(3'($urandom_range(0, 7)), $urandom, $urandom, any_emcy());
          end
        end
      endcase
    end
  endtask

  // Configuration write. Only called while the sequencer has nothing in flight.
  task automatic write_reg(input logic idx, input logic [6:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == des_pkg::REG_POSITION_MODE) cfg_pos_mode = data[0];
    else cfg_node = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued item has been taken and every predicted frame has been
  // checked, then waits out the tail cycles so the pipeline is truly empty.
  task automatic wait_drained(input int tail);
    do @(negedge clk_i); while (items_accepted != items_total || frames_due.size() != 0);
    repeat (tail) @(negedge clk_i);
  endtask

  // Watchdog: ends the run if no transfer happens for too long.
  initial begin : watchdog
    while (stall_cycles < WATCHDOG_CYCLES) @(negedge clk_i);
    $display("drive_enable_sequencer_core_test: done, errors");
    $finish;
  end

  initial begin : run_test
    logic       pm;
    logic [6:0] node;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the configuration left by reset (velocity mode, node 1).
    stall_odds = 3;
    add_item(des_pkg::OP_STATUS, 'h0000, 'h0, 'h0);              // disabled: control word off
    add_item(des_pkg::OP_TARGET, 'hFFFF, 'h7FFF_FFFF, 'hFFFF);   // not operational, no delay
    add_item(des_pkg::OP_ENABLE, $urandom, $urandom, $urandom);
    add_item(des_pkg::OP_TARGET, $urandom, 'h8000_0000, $urandom); // inside start-up delay
    add_item(des_pkg::OP_STATUS, 'h0008, $urandom, $urandom);    // fault reset word
    add_item(des_pkg::OP_STATUS, 'h0008, $urandom, $urandom);    // second faulted frame reads
    add_item(des_pkg::OP_STATUS, sw_with(NIB_NOT_READY), $urandom, $urandom);
    add_item(des_pkg::OP_STATUS, sw_with(NIB_READY), $urandom, $urandom);
    add_item(des_pkg::OP_STATUS, sw_with(NIB_SWITCHED_ON), $urandom, $urandom);
    add_item(des_pkg::OP_STATUS, sw_with(NIB_OP_ENABLED), $urandom, $urandom);
    add_item(des_pkg::OP_TARGET, $urandom, 'd12345, $urandom);
    add_item(des_pkg::OP_EMCY, $urandom, $urandom, {16'h0, EMCY_LIST[0]});
    add_item(des_pkg::OP_EMCY, $urandom, $urandom, 'hFFFF);      // not in the code list
    add_item(des_pkg::OP_TIMEOUT, $urandom, $urandom, $urandom);
    add_item(des_pkg::OP_STATUS, 'hFFF7, $urandom, $urandom);    // clears the timeout fault
    add_item(des_pkg::OP_STATUS, 'hFFFF, $urandom, $urandom);    // fault drops the enable
    repeat (5) begin
      add_item(des_pkg::OP_STATUS, 'h0008, $urandom, $urandom);  // fault latches on the sixth
    end
    add_item(des_pkg::OP_EMCY, $urandom, $urandom, {16'h0, EMCY_LIST[24]});
    add_item(des_pkg::OP_TARGET, $urandom, 'hFFFF_FFFF, $urandom); // refused while faulted
    add_item(des_pkg::OP_DISABLE, $urandom, $urandom, $urandom);
    add_item(OP_SPARE_A, $urandom, $urandom, $urandom);
    add_item(OP_SPARE_B, $urandom, $urandom, $urandom);
    wait_drained(4);

    // Random phases, each under its own configuration. Both extremes of the node number
    // and both modes are covered; the last phase runs with no idling at all.
    for (int ph = 0; ph < 6; ph++) begin
      pm = !ph[0];
      case (ph)
        0:       node = 7'd127;
        1, 4:    node = 7'd1;
        default: node = 7'($urandom_range(1, 127));
      endcase
      if (ph == 5) pm = 1'($urandom_range(0, 1));
      write_reg(des_pkg::REG_POSITION_MODE, {6'b0, pm});
      write_reg(des_pkg::REG_NODE_ID, node);
      @(posedge clk_i);
      stall_odds = (ph == 5) ? 0 : $urandom_range(2, 8);
      // A long faulted stretch reaches the periodic error-code read a second time.
      if (ph == 1) queue_fault_run(READ_EVERY + 2);
      // Let the start-up delay run out: the target just before expiry is accepted,
      // the one right after is refused as not yet operational.
      if (ph == 2) begin
        add_item(des_pkg::OP_ENABLE, $urandom, $urandom, $urandom);
        add_item(des_pkg::OP_STATUS, sw_with(NIB_NOT_READY), $urandom, $urandom);
        repeat (SETTLE_FRAMES - 2) begin
          add_item(des_pkg::OP_STATUS, sw_with(NIB_READY), $urandom, $urandom);
        end
        add_item(des_pkg::OP_TARGET, $urandom, $urandom, $urandom);
        add_item(des_pkg::OP_STATUS, sw_with(NIB_READY), $urandom, $urandom);
        add_item(des_pkg::OP_TARGET, $urandom, $urandom, $urandom);
      end
      queue_random_phase(5);
      wait_drained(ph == 5 ? 10 : 4);
    end

    if (error_count == 0) begin
      $display("drive_enable_sequencer_core_test: done, clean");
    end else begin
      $display("drive_enable_sequencer_core_test: done, errors");
    end
    $finish;
  end

endmodule
